// ===== hdl/pfbu_pkg.sv =====
// ----------------------------------------------------------------------------
// pfbu_pkg
// Types and codes shared by the PReLU forward/backward unit.
// ----------------------------------------------------------------------------
package pfbu_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 40;
  localparam int INDEX_W  = 8;
  localparam int PROD_W   = 2 * SAMPLE_W;

  typedef enum logic [1:0] {
    ACT_WRITE_SLOPE = 2'd0,
    ACT_PROCESS     = 2'd1,
    ACT_READ_SUM    = 2'd2,
    ACT_CLEAR_SUM   = 2'd3
  } action_t;

  localparam logic [1:0] PASS_FORWARD    = 2'd0;
  localparam logic [1:0] PASS_INPUT_GRAD = 2'd1;
  localparam logic [1:0] PASS_SLOPE_GRAD = 2'd2;

  localparam logic [1:0] LAYOUT_SHARED      = 2'd0;
  localparam logic [1:0] LAYOUT_PLANES      = 2'd1;
  localparam logic [1:0] LAYOUT_INTERLEAVED = 2'd2;

  localparam logic [1:0] REG_PASS_KIND  = 2'd0;
  localparam logic [1:0] REG_LAYOUT     = 2'd1;
  localparam logic [1:0] REG_CHANNELS   = 2'd2;
  localparam logic [1:0] REG_PLANE_SIZE = 2'd3;

  typedef struct packed {
    action_t                     action;
    logic [INDEX_W-1:0]          index;
    logic signed [SAMPLE_W-1:0]  slope_value;
    logic signed [SAMPLE_W-1:0]  sample_x;
    logic signed [SAMPLE_W-1:0]  upstream_grad;
    logic                        start_of_tensor;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  result_value;
    logic signed [ACC_W-1:0]     grad_sum;
    logic [INDEX_W-1:0]          channel_used;
    logic                        saturated;
  } result_t;

endpackage

// ===== hdl/pfbu_sum_mem.sv =====
// ----------------------------------------------------------------------------
// pfbu_sum_mem
// Slope-gradient sum memory: one read and one write port, registered read,
// bypass of writes that land on the read edge or the cycle after it, and a
// zeroing sweep after reset.
// ----------------------------------------------------------------------------
module pfbu_sum_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [ADDR_W-1:0]               rd_addr,
  output logic signed [pfbu_pkg::ACC_W-1:0] rd_data,
  input  logic                            wr_en,
  input  logic [ADDR_W-1:0]               wr_addr,
  input  logic signed [pfbu_pkg::ACC_W-1:0] wr_data,
  output logic                            busy
);

  logic signed [pfbu_pkg::ACC_W-1:0] mem [DEPTH];
  logic signed [pfbu_pkg::ACC_W-1:0] rd_q;
  logic [ADDR_W-1:0]                 rd_addr_q;
  logic                              lw_hit;
  logic signed [pfbu_pkg::ACC_W-1:0] lw_data;
  logic [ADDR_W-1:0]                 clr_addr;

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      lw_hit    <= wr_en && (wr_addr == rd_addr);
      lw_data   <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_comb begin
    if (wr_en && (wr_addr == rd_addr_q)) begin
      rd_data = wr_data;
    end else if (lw_hit) begin
      rd_data = lw_data;
    end else begin
      rd_data = rd_q;
    end
  end

  a_no_access_in_sweep: assert property (@(posedge clk) disable iff (rst)
    busy |-> (!rd_en && !wr_en))
    else $error("sum memory accessed during zeroing sweep");

  a_sweep_covers_all: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ($past(clr_addr) == ADDR_W'(DEPTH - 1)))
    else $error("zeroing sweep ended early");

endmodule

// ===== hdl/prelu_forward_backward_unit_top.sv =====
// ----------------------------------------------------------------------------
// prelu_forward_backward_unit_top
// Parametric ReLU forward, input-gradient and slope-gradient streaming unit.
// ----------------------------------------------------------------------------
// Takes one word per cycle while item_ready is high. After a word is accepted,
// its result passes slope and sum memory read, multiply, then round/saturate
// and sum update with write-back, and is held in the output register. Sum
// reads that hit a write still in flight are bypassed, so back-to-back words
// on one channel are fine. After reset all MAX_CHANNELS sum memory entries are
// zeroed, during which item_ready stays low; APB writes are taken throughout.
module prelu_forward_backward_unit_top #(
  parameter int MAX_CHANNELS = 256,
  parameter int FRAC_BITS    = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  pfbu_pkg::item_t         item,
  output logic                    result_valid,
  input  logic                    result_ready,
  output pfbu_pkg::result_t       result
);

  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = (CW + 1 > 9) ? CW + 1 : 9;
  localparam int SW    = pfbu_pkg::SAMPLE_W;
  localparam int AW    = pfbu_pkg::ACC_W;
  localparam int PW    = pfbu_pkg::PROD_W;
  localparam logic [PW:0] RND = (PW+1)'((33'(1) << FRAC_BITS) >> 1);

  // configuration
  logic [1:0]  pass_kind;
  logic [1:0]  layout;
  logic [8:0]  channels_in_use;
  logic [16:0] plane_size;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_kind       <= pfbu_pkg::PASS_FORWARD;
      layout          <= pfbu_pkg::LAYOUT_PLANES;
      channels_in_use <= 9'd1;
      plane_size      <= 17'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        pfbu_pkg::REG_PASS_KIND:  pass_kind       <= pwdata[1:0];
        pfbu_pkg::REG_LAYOUT:     layout          <= pwdata[1:0];
        pfbu_pkg::REG_CHANNELS:   channels_in_use <= pwdata[8:0];
        pfbu_pkg::REG_PLANE_SIZE: plane_size      <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pfbu_pkg::REG_PASS_KIND:  prdata = {30'd0, pass_kind};
      pfbu_pkg::REG_LAYOUT:     prdata = {30'd0, layout};
      pfbu_pkg::REG_CHANNELS:   prdata = {23'd0, channels_in_use};
      pfbu_pkg::REG_PLANE_SIZE: prdata = {15'd0, plane_size};
      default:                  prdata = '0;
    endcase
  end

  // pipeline control
  logic sum_busy;
  logic adv;
  logic accept;

  assign adv        = !result_valid || result_ready;
  assign item_ready = adv && !sum_busy;
  assign accept     = item_valid && item_ready;

  // stage 0: channel tracking
  logic [CW-1:0]    channel_counter;
  logic [15:0]      plane_position;
  logic [CW-1:0]    cc_eff;
  logic [15:0]      pos_eff;
  logic [CW-1:0]    cc_wrap;
  logic [CW-1:0]    cc_next;
  logic [15:0]      pos_next;
  logic [CW-1:0]    chan;
  logic [CNT_W-1:0] chans;
  logic [CNT_W-1:0] cc_inc;
  logic [16:0]      plane;
  logic [16:0]      pos_inc;
  logic [CNT_W-1:0] idx_ext;
  logic             idx_in_range;
  logic [CW-1:0]    mem_addr;
  logic [7:0]       chan_out;

  always_comb begin
    if (channels_in_use == 9'd0) begin
      chans = CNT_W'(1);
    end else if (CNT_W'(channels_in_use) > CNT_W'(MAX_CHANNELS)) begin
      chans = CNT_W'(MAX_CHANNELS);
    end else begin
      chans = CNT_W'(channels_in_use);
    end
    if (plane_size == 17'd0) begin
      plane = 17'd1;
    end else if (plane_size > 17'd65536) begin
      plane = 17'd65536;
    end else begin
      plane = plane_size;
    end

    cc_eff  = item.start_of_tensor ? '0 : channel_counter;
    pos_eff = item.start_of_tensor ? '0 : plane_position;
    cc_inc  = CNT_W'(cc_eff) + CNT_W'(1);
    cc_wrap = (cc_inc >= chans) ? '0 : cc_inc[CW-1:0];
    pos_inc = {1'b0, pos_eff} + 17'd1;

    case (layout)
      pfbu_pkg::LAYOUT_PLANES: begin
        chan = cc_eff;
        if (pos_inc >= plane) begin
          pos_next = '0;
          cc_next  = cc_wrap;
        end else begin
          pos_next = pos_inc[15:0];
          cc_next  = cc_eff;
        end
      end
      pfbu_pkg::LAYOUT_INTERLEAVED: begin
        chan     = cc_eff;
        pos_next = pos_eff;
        cc_next  = cc_wrap;
      end
      default: begin
        chan     = '0;
        pos_next = pos_eff;
        cc_next  = cc_eff;
      end
    endcase

    idx_ext      = CNT_W'(item.index);
    idx_in_range = idx_ext < CNT_W'(MAX_CHANNELS);
    if (item.action == pfbu_pkg::ACT_PROCESS) begin
      mem_addr = chan;
      chan_out = 8'(CNT_W'(chan));
    end else begin
      mem_addr = idx_ext[CW-1:0];
      chan_out = item.index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_counter <= '0;
      plane_position  <= '0;
    end else if (accept && item.action == pfbu_pkg::ACT_PROCESS) begin
      channel_counter <= cc_next;
      plane_position  <= pos_next;
    end
  end

  // slope memory
  logic signed [SW-1:0] slope_mem [MAX_CHANNELS];
  logic signed [SW-1:0] slope_rd;

  always_ff @(posedge clk) begin
    if (accept && item.action == pfbu_pkg::ACT_WRITE_SLOPE && idx_in_range) begin
      slope_mem[mem_addr] <= item.slope_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slope_rd <= slope_mem[mem_addr];
    end
  end

  // sum memory
  logic signed [AW-1:0] sum_rd;
  logic                 sum_wr_en;
  logic [CW-1:0]        s2_addr;
  logic signed [AW-1:0] sum_wr_data;

  pfbu_sum_mem #(
    .DEPTH  (MAX_CHANNELS),
    .ADDR_W (CW)
  ) u_sum_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (mem_addr),
    .rd_data (sum_rd),
    .wr_en   (sum_wr_en),
    .wr_addr (s2_addr),
    .wr_data (sum_wr_data),
    .busy    (sum_busy)
  );

  // stage 1: multiply
  logic                 s1_valid;
  pfbu_pkg::action_t    s1_action;
  logic                 s1_in_range;
  logic [7:0]           s1_chan;
  logic [CW-1:0]        s1_addr;
  logic signed [SW-1:0] s1_x;
  logic signed [SW-1:0] s1_dy;
  logic signed [SW-1:0] s1_operand;
  logic signed [PW-1:0] s1_prod_s;
  logic signed [PW-1:0] s1_prod_dx;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_action   <= item.action;
      s1_in_range <= idx_in_range;
      s1_chan     <= chan_out;
      s1_addr     <= mem_addr;
      s1_x        <= item.sample_x;
      s1_dy       <= item.upstream_grad;
    end
  end

  assign s1_operand = (pass_kind == pfbu_pkg::PASS_INPUT_GRAD) ? s1_dy : s1_x;
  assign s1_prod_s  = slope_rd * s1_operand;
  assign s1_prod_dx = s1_dy * s1_x;

  // stage 2: round, saturate, accumulate
  logic                 s2_valid;
  pfbu_pkg::action_t    s2_action;
  logic                 s2_in_range;
  logic [7:0]           s2_chan;
  logic signed [SW-1:0] s2_x;
  logic signed [SW-1:0] s2_dy;
  logic signed [PW-1:0] s2_prod_s;
  logic signed [PW-1:0] s2_prod_dx;
  logic signed [AW-1:0] s2_sum_old;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_action   <= s1_action;
      s2_in_range <= s1_in_range;
      s2_chan     <= s1_chan;
      s2_addr     <= s1_addr;
      s2_x        <= s1_x;
      s2_dy       <= s1_dy;
      s2_prod_s   <= s1_prod_s;
      s2_prod_dx  <= s1_prod_dx;
      s2_sum_old  <= sum_rd;
    end
  end

  logic signed [PW:0]   rounded;
  logic                 scale_clip;
  logic signed [SW-1:0] scaled;
  logic signed [AW:0]   acc_sum;
  logic                 acc_clip;
  logic signed [AW-1:0] acc_new;
  logic                 x_pos;
  logic                 grad_take;
  pfbu_pkg::result_t    res_next;

  always_comb begin
    rounded    = ($signed({s2_prod_s[PW-1], s2_prod_s}) + $signed(RND)) >>> FRAC_BITS;
    scale_clip = !((&rounded[PW:SW-1]) || !(|rounded[PW:SW-1]));
    if (scale_clip) begin
      scaled = rounded[PW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      scaled = rounded[SW-1:0];
    end

    acc_sum  = {s2_sum_old[AW-1], s2_sum_old} + (AW+1)'(s2_prod_dx);
    acc_clip = acc_sum[AW] != acc_sum[AW-1];
    if (acc_clip) begin
      acc_new = acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      acc_new = acc_sum[AW-1:0];
    end

    x_pos     = s2_x > 0;
    grad_take = s2_action == pfbu_pkg::ACT_PROCESS &&
                pass_kind == pfbu_pkg::PASS_SLOPE_GRAD && !x_pos;

    res_next              = '0;
    res_next.channel_used = s2_chan;
    case (s2_action)
      pfbu_pkg::ACT_PROCESS: begin
        case (pass_kind)
          pfbu_pkg::PASS_INPUT_GRAD: begin
            res_next.result_value = x_pos ? s2_dy : scaled;
            res_next.saturated    = !x_pos && scale_clip;
          end
          pfbu_pkg::PASS_SLOPE_GRAD: begin
            res_next.grad_sum  = x_pos ? s2_sum_old : acc_new;
            res_next.saturated = !x_pos && acc_clip;
          end
          default: begin
            res_next.result_value = x_pos ? s2_x : scaled;
            res_next.saturated    = !x_pos && scale_clip;
          end
        endcase
      end
      pfbu_pkg::ACT_READ_SUM: begin
        res_next.grad_sum = s2_in_range ? s2_sum_old : '0;
      end
      default: ;
    endcase

    sum_wr_en   = adv && s2_valid &&
                  (grad_take ||
                   (s2_action == pfbu_pkg::ACT_CLEAR_SUM && s2_in_range));
    sum_wr_data = grad_take ? acc_new : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= accept;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |-> !sum_busy)
    else $error("word accepted during sum memory sweep");

  a_stage2_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid) |=> result_valid)
    else $error("stage 2 word lost");

  a_channel_in_range: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (CNT_W'(channel_counter) < CNT_W'(MAX_CHANNELS)))
    else $error("channel counter beyond table");

  a_no_write_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !adv |-> !sum_wr_en)
    else $error("sum write while pipeline stalled");

endmodule
